// ----- src/imu_frame_unpack_gyro_bias_assert.svh -----
// ----------------------------------------------------------------------------
// IMU frame unpack assertion macros
// Concurrent assertion wrappers on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_UNPACK_GYRO_BIAS_ASSERT_SVH
`define IMU_FRAME_UNPACK_GYRO_BIAS_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define IMUFUB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be true out of reset
`define IMUFUB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define IMUFUB_ASSERT(lbl, prop, msg)
`define IMUFUB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- src/imufub_pkg.sv -----
// ----------------------------------------------------------------------------
// IMU frame unpack package
// Shared widths, constants and item types of the frame unpack block.
// ----------------------------------------------------------------------------
package imufub_pkg;

  localparam int CAL_FRAMES  = 500;
  localparam int BURST_BYTES = 14;
  localparam int STORE_DEPTH = BURST_BYTES - 1;
  localparam int POS_W       = $clog2(BURST_BYTES);
  localparam int CNT_W       = 9;
  localparam int SUM_W       = 25;
  localparam int WORD_W      = 16;
  localparam int OPQ_DEPTH   = 4;
  localparam int NUM_AXES    = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_FRAME = 1'b1
  } op_kind_e;

  typedef enum logic [1:0] {
    BK_RUN = 2'b01,
    BK_DIV = 2'b10
  } bk_state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] accel_x;
    logic signed [WORD_W-1:0] accel_y;
    logic signed [WORD_W-1:0] accel_z;
    logic signed [WORD_W-1:0] gyro_x;
    logic signed [WORD_W-1:0] gyro_y;
    logic signed [WORD_W-1:0] gyro_z;
    logic                     calibrating;
    logic                     offsets_updated;
  } out_item_t;

  // work item handed from the byte front end to the back end
  typedef struct packed {
    op_kind_e                 kind;
    logic signed [WORD_W-1:0] accel_x;
    logic signed [WORD_W-1:0] accel_y;
    logic signed [WORD_W-1:0] accel_z;
    logic signed [WORD_W-1:0] gyro_x;
    logic signed [WORD_W-1:0] gyro_y;
    logic signed [WORD_W-1:0] gyro_z;
  } op_t;

endpackage

// ----- src/imu_frame_unpack_gyro_bias.sv -----
// ----------------------------------------------------------------------------
// IMU frame unpack with gyro bias calibration
// Unpacks 14-byte inertial bursts into accel and bias-corrected gyro words.
// ----------------------------------------------------------------------------
// Input queue side: one beat per push with full low. A data beat (mode 0)
// carries one burst byte; first_byte restarts the burst. A start beat
// (mode 1) clears offsets and sums and begins a calibration run.
// Output queue side: while empty is low the oldest result is on out_item_o
// and leaves on pop. One result per 14th burst byte.
// Throughput: one beat per cycle while full is low; the byte front end never stalls on its own.
// With both queues idle, a frame's result is registered in the work queue and
// then in the result queue before it shows on out_item_o and can leave on pop.
// The last calibration frame starts a reciprocal divide (three axes
// in parallel); the back end holds its 4-entry work queue meanwhile, so
// beats pile up there and full can rise if the queue was nearly full.
// A stalled receiver fills the 2-entry result queue, then the work queue,
// then full rises. Reset clears byte position, offsets, sums and all queues.
// ----------------------------------------------------------------------------
module imu_frame_unpack_gyro_bias import imufub_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic accept;
  logic op_push, op_pop, op_empty;
  op_t  op_in, op_out;

  assign accept = push && !full;

  imufub_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .op_push_o (op_push),
    .op_o      (op_in)
  );

  imufub_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .op_i    (op_in),
    .full_o  (full),
    .pop_i   (op_pop),
    .op_o    (op_out),
    .empty_o (op_empty)
  );

  imufub_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (op_empty),
    .op_i       (op_out),
    .op_pop_o   (op_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .item_o     (out_item_o)
  );

endmodule

// ----- src/imufub_front.sv -----
// ----------------------------------------------------------------------------
// IMU frame unpack front end
// Collects burst bytes, assembles complete frames and emits work items.
// ----------------------------------------------------------------------------
module imufub_front import imufub_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     op_push_o,
  output op_t      op_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       store_q [STORE_DEPTH];
  logic             store_wr;
  logic             frame_done;

  assign pos_eff    = item_i.first_byte ? '0 : pos_q;
  assign frame_done = accept_i && !item_i.mode && (pos_eff == POS_W'(STORE_DEPTH));
  assign store_wr   = accept_i && !item_i.mode && (pos_eff != POS_W'(STORE_DEPTH));

  always_comb begin
    pos_d = pos_q;
    if (store_wr) begin
      pos_d = pos_eff + POS_W'(1);
    end else if (frame_done) begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[pos_eff] <= item_i.data_byte;
    end
  end

  // a start beat goes out at once; a data beat only on the last burst byte
  assign op_push_o = accept_i && (item_i.mode || frame_done);

  always_comb begin
    op_o.kind    = item_i.mode ? OP_START : OP_FRAME;
    op_o.accel_x = {store_q[0], store_q[1]};
    op_o.accel_y = {store_q[2], store_q[3]};
    op_o.accel_z = {store_q[4], store_q[5]};
    op_o.gyro_x  = {store_q[8], store_q[9]};
    op_o.gyro_y  = {store_q[10], store_q[11]};
    op_o.gyro_z  = {store_q[12], item_i.data_byte};
  end

endmodule

// ----- src/imufub_opq.sv -----
// ----------------------------------------------------------------------------
// IMU frame unpack work queue
// Short queue of work items between the front end and the back end.
// ----------------------------------------------------------------------------
module imufub_opq import imufub_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  op_o,
  output logic empty_o
);

  localparam int PTR_W = $clog2(OPQ_DEPTH);
  localparam int CNT_QW = $clog2(OPQ_DEPTH + 1);

  op_t               mem_q [OPQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_QW'(OPQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ----- src/imufub_div.sv -----
// ----------------------------------------------------------------------------
// IMU frame unpack bias divider
// Three-lane divide of the bias sums by CAL_FRAMES, truncated toward zero,
// done as a reciprocal multiply on the registered sum magnitudes.
// ----------------------------------------------------------------------------
module imufub_div import imufub_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  sum_t  sums_i [NUM_AXES],
  output logic  done_o,
  output word_t quot_o [NUM_AXES]
);

  // magnitudes stay below 2^24: at most CAL_FRAMES sums of 16-bit words
  localparam int MAG_W   = SUM_W - 1;
  localparam int SHIFT   = MAG_W + CNT_W;
  localparam int RECIP_W = SUM_W;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(CAL_FRAMES) - 64'd1) / 64'(CAL_FRAMES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [MAG_W-1:0]  mag_q [NUM_AXES];
  logic              neg_q [NUM_AXES];
  logic [WORD_W-1:0] qmag_q [NUM_AXES];
  logic [PROD_W-1:0] prod [NUM_AXES];
  logic              busy_q, done_q;

  // rounded-up reciprocal keeps floor(mag * RECIP >> SHIFT) exact for MAG_W bits
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      prod[i] = PROD_W'(mag_q[i]) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (start_i) begin
        neg_q[i] <= sums_i[i][SUM_W-1];
        mag_q[i] <= sums_i[i][SUM_W-1] ? MAG_W'(-sums_i[i]) : MAG_W'(sums_i[i]);
      end
      if (busy_q) begin
        qmag_q[i] <= prod[i][SHIFT +: WORD_W];
      end
    end
  end

  assign done_o = done_q;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      quot_o[i] = neg_q[i] ? -word_t'(qmag_q[i])
                           : word_t'(qmag_q[i]);
    end
  end

endmodule

// ----- src/imufub_back.sv -----
// ----------------------------------------------------------------------------
// IMU frame unpack back end
// Applies gyro offsets, runs the bias calibration and queues results.
// ----------------------------------------------------------------------------
`include "imu_frame_unpack_gyro_bias_assert.svh"

module imufub_back import imufub_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_empty_i,
  input  op_t       op_i,
  output logic      op_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t item_o
);

  localparam int OQ_DEPTH = 2;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  bk_state_e         state_q, state_d;
  word_t             offs_q [NUM_AXES];
  word_t             offs_d [NUM_AXES];
  sum_t              sum_q [NUM_AXES];
  sum_t              sum_d [NUM_AXES];
  sum_t              sum_add [NUM_AXES];
  word_t             raw [NUM_AXES];
  word_t             quot [NUM_AXES];
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic              active_q, active_d;
  logic              op_pop, is_frame, is_start, last_frame;
  logic              div_start, div_done;
  out_item_t         res;

  out_item_t         oq_mem_q [OQ_DEPTH];
  logic [OQ_PW-1:0]  oq_wr_q, oq_rd_q;
  logic [OQ_CW-1:0]  oq_cnt_q;
  logic              oq_full, oq_push, oq_pop;

  assign oq_full  = (oq_cnt_q == OQ_CW'(OQ_DEPTH));
  assign empty_o  = (oq_cnt_q == '0);
  assign oq_pop   = pop_i && !empty_o;
  assign item_o   = oq_mem_q[oq_rd_q];

  // a start needs no result slot; a frame waits for one
  assign op_pop   = (state_q == BK_RUN) && !op_empty_i &&
                    ((op_i.kind == OP_START) || !oq_full);
  assign op_pop_o = op_pop;
  assign is_frame = op_pop && (op_i.kind == OP_FRAME);
  assign is_start = op_pop && (op_i.kind == OP_START);
  assign oq_push  = is_frame;

  assign raw[0] = op_i.gyro_x;
  assign raw[1] = op_i.gyro_y;
  assign raw[2] = op_i.gyro_z;

  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign last_frame = is_frame && active_q && (cnt_inc >= CNT_W'(CAL_FRAMES));
  assign div_start  = last_frame;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sum_add[i] = sum_q[i] + {{(SUM_W - WORD_W){raw[i][WORD_W-1]}}, raw[i]};
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      offs_d[i] = offs_q[i];
      sum_d[i]  = sum_q[i];
    end
    case (state_q)
      BK_RUN: begin
        if (is_start) begin
          cnt_d    = '0;
          active_d = 1'b1;
          for (int i = 0; i < NUM_AXES; i++) begin
            offs_d[i] = '0;
            sum_d[i]  = '0;
          end
        end else if (is_frame && active_q) begin
          cnt_d = cnt_inc;
          for (int i = 0; i < NUM_AXES; i++) begin
            sum_d[i] = sum_add[i];
          end
          if (last_frame) begin
            active_d = 1'b0;
            state_d  = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        // hold the queue until the new offsets are loaded
        if (div_done) begin
          state_d = BK_RUN;
          for (int i = 0; i < NUM_AXES; i++) begin
            offs_d[i] = quot[i];
          end
        end
      end
      default: begin
        state_d = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_RUN;
      cnt_q    <= '0;
      active_q <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        offs_q[i] <= '0;
        sum_q[i]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
      for (int i = 0; i < NUM_AXES; i++) begin
        offs_q[i] <= offs_d[i];
        sum_q[i]  <= sum_d[i];
      end
    end
  end

  imufub_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sums_i  (sum_add),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    res.accel_x         = op_i.accel_x;
    res.accel_y         = op_i.accel_y;
    res.accel_z         = op_i.accel_z;
    res.gyro_x          = raw[0] - offs_q[0];
    res.gyro_y          = raw[1] - offs_q[1];
    res.gyro_z          = raw[2] - offs_q[2];
    res.calibrating     = active_q;
    res.offsets_updated = last_frame;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + OQ_PW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OQ_PW'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + OQ_CW'(1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt_q <= oq_cnt_q - OQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem_q[oq_wr_q] <= res;
    end
  end

  `IMUFUB_ASSERT(a_div_holds_queue, (state_q == BK_DIV) |-> !op_pop_o, "work item taken during divide")
  `IMUFUB_ASSERT(a_done_in_div, div_done |-> (state_q == BK_DIV), "divider done outside divide state")
  `IMUFUB_ASSERT(a_cal_end_divides, $fell(active_q) |-> (state_q == BK_DIV), "calibration ended without divide")
  `IMUFUB_ASSERT(a_upd_while_cal, (oq_push && res.offsets_updated) |-> res.calibrating, "offsets updated outside calibration")
  `IMUFUB_ASSERT_NEVER(a_oq_overflow, oq_push && oq_full, "result pushed into full queue")

endmodule
